// ===== hdl/vdt_pkg.sv =====
// Shared types and constants of the muon veto dead-time tracker.
package vdt_pkg;

  localparam int HIT_W  = 14;
  localparam int FLAG_W = 16;
  localparam int WIN_W  = 48;
  localparam int SUM_W  = 64;
  localparam int CNT_W  = 32;
  localparam int CFG_W  = 48;
  localparam int CFG_IDX_W = 1;

  localparam int FLAG_MUON_CUT_BIT     = 7;
  localparam int FLAG_FOLLOWER_CUT_BIT = 14;

  localparam logic [HIT_W-1:0] HIT_THR_RST = 14'd3000;
  localparam logic [WIN_W-1:0] WIN_NS_RST  = 48'd20000000000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HIT_THRESHOLD = 1'b0,
    CFG_VETO_WINDOW   = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic             accept;
    logic [CNT_W-1:0] veto_total;
    logic [SUM_W-1:0] pileup_ns;
    logic [SUM_W-1:0] lone_follower_ns;
  } res_t;

  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                               input logic [SUM_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
  endfunction

endpackage

// ===== hdl/vdt_in_reg.sv =====
// Input register stage: holds one event request until the update stage takes it.
module vdt_in_reg #(
  parameter int STAMP_BITS = 43
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [STAMP_BITS-1:0]         in_timestamp,
  input  logic [vdt_pkg::HIT_W-1:0]     in_cleaned_hits,
  input  logic [vdt_pkg::FLAG_W-1:0]    in_cleaning_flags,
  output logic                          item_valid,
  input  logic                          item_take,
  output logic [STAMP_BITS-1:0]         item_stamp,
  output logic [vdt_pkg::HIT_W-1:0]     item_hits,
  output logic [vdt_pkg::FLAG_W-1:0]    item_flags
);
  import vdt_pkg::*;

  logic                  valid_r;
  logic                  valid_nxt;
  logic [STAMP_BITS-1:0] stamp_r;
  logic [HIT_W-1:0]      hits_r;
  logic [FLAG_W-1:0]     flags_r;
  logic                  load;

  assign in_stall = valid_r && !item_take;
  assign load     = in_valid && !in_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (item_take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      stamp_r <= in_timestamp;
      hits_r  <= in_cleaned_hits;
      flags_r <= in_cleaning_flags;
    end
  end

  assign item_valid = valid_r;
  assign item_stamp = stamp_r;
  assign item_hits  = hits_r;
  assign item_flags = flags_r;

endmodule

// ===== hdl/vdt_state.sv =====
// Veto and lone-follower window state, config registers and per-event update.
module vdt_state #(
  parameter int STAMP_BITS = 43
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [vdt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [vdt_pkg::CFG_W-1:0]       cfg_wdata,
  input  logic                            adv,
  input  logic [STAMP_BITS-1:0]           item_stamp,
  input  logic [vdt_pkg::HIT_W-1:0]       item_hits,
  input  logic [vdt_pkg::FLAG_W-1:0]      item_flags,
  output vdt_pkg::res_t                   res
);
  import vdt_pkg::*;

  localparam int PROD_W = STAMP_BITS + 5;
  localparam int EXT_W  = (PROD_W > SUM_W) ? PROD_W : SUM_W + 1;

  logic [HIT_W-1:0]      hit_thr_r;
  logic [WIN_W-1:0]      win_ns_r;

  logic                  veto_open_r, veto_open_nxt;
  logic                  lone_open_r, lone_open_nxt;
  logic [STAMP_BITS-1:0] veto_start_r, veto_start_nxt;
  logic [STAMP_BITS-1:0] lone_start_r, lone_start_nxt;
  logic [SUM_W-1:0]      pileup_r, pileup_nxt;
  logic [SUM_W-1:0]      lone_sum_r, lone_sum_nxt;
  logic [CNT_W-1:0]      veto_cnt_r, veto_cnt_nxt;

  logic                  muon;
  logic                  accept;
  logic [SUM_W-1:0]      el_veto;
  logic [SUM_W-1:0]      el_lone;

  function automatic logic [SUM_W-1:0] elapsed_ns(input logic [STAMP_BITS-1:0] now,
                                                  input logic [STAMP_BITS-1:0] start);
    logic [STAMP_BITS-1:0] d;
    logic [PROD_W-1:0]     p;
    logic [EXT_W-1:0]      e;
    d = now - start;
    // ticks * 20 = ticks * 16 + ticks * 4
    p = PROD_W'({d, 4'b0000}) + PROD_W'({d, 2'b00});
    e = EXT_W'(p);
    return (|e[EXT_W-1:SUM_W]) ? {SUM_W{1'b1}} : e[SUM_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_thr_r <= HIT_THR_RST;
      win_ns_r  <= WIN_NS_RST;
    end else if (cfg_wr_en) begin
      case (cfg_idx_t'(cfg_index))
        CFG_HIT_THRESHOLD: hit_thr_r <= cfg_wdata[HIT_W-1:0];
        CFG_VETO_WINDOW:   win_ns_r  <= cfg_wdata[WIN_W-1:0];
        default: ;
      endcase
    end
  end

  assign el_veto = elapsed_ns(item_stamp, veto_start_r);
  assign el_lone = elapsed_ns(item_stamp, lone_start_r);
  assign muon    = !item_flags[FLAG_MUON_CUT_BIT] && (item_hits > hit_thr_r);

  always_comb begin
    veto_open_nxt  = veto_open_r;
    lone_open_nxt  = lone_open_r;
    veto_start_nxt = veto_start_r;
    lone_start_nxt = lone_start_r;
    pileup_nxt     = pileup_r;
    lone_sum_nxt   = lone_sum_r;
    veto_cnt_nxt   = veto_cnt_r;
    accept         = 1'b0;
    if (adv) begin
      if (muon) begin
        if (lone_open_r) begin
          lone_sum_nxt  = sat_add(lone_sum_r, el_lone);
          lone_open_nxt = 1'b0;
        end
        if (!veto_open_r) begin
          if (veto_cnt_r != {CNT_W{1'b1}}) begin
            veto_cnt_nxt = veto_cnt_r + CNT_W'(1);
          end
          veto_open_nxt = 1'b1;
        end else begin
          pileup_nxt = sat_add(pileup_r, el_veto);
        end
        veto_start_nxt = item_stamp;
      end else if (veto_open_r && (el_veto < {{(SUM_W-WIN_W){1'b0}}, win_ns_r})) begin
        accept = 1'b0;
      end else begin
        veto_open_nxt = 1'b0;
        if (!item_flags[FLAG_FOLLOWER_CUT_BIT]) begin
          if (lone_open_r) begin
            lone_sum_nxt = sat_add(lone_sum_r, el_lone);
          end
          lone_open_nxt  = 1'b1;
          lone_start_nxt = item_stamp;
        end else begin
          lone_open_nxt = 1'b0;
          accept        = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      veto_open_r  <= 1'b0;
      lone_open_r  <= 1'b0;
      veto_start_r <= '0;
      lone_start_r <= '0;
      pileup_r     <= '0;
      lone_sum_r   <= '0;
      veto_cnt_r   <= '0;
    end else begin
      veto_open_r  <= veto_open_nxt;
      lone_open_r  <= lone_open_nxt;
      veto_start_r <= veto_start_nxt;
      lone_start_r <= lone_start_nxt;
      pileup_r     <= pileup_nxt;
      lone_sum_r   <= lone_sum_nxt;
      veto_cnt_r   <= veto_cnt_nxt;
    end
  end

  always_comb begin
    res.accept           = accept;
    res.veto_total       = veto_cnt_nxt;
    res.pileup_ns        = pileup_nxt;
    res.lone_follower_ns = lone_sum_nxt;
  end

  a_cnt_mono: assert property (@(posedge clk) disable iff (!rst_n)
    veto_cnt_r >= $past(veto_cnt_r))
    else $error("veto count decreased");

  a_sums_mono: assert property (@(posedge clk) disable iff (!rst_n)
    (pileup_r >= $past(pileup_r)) && (lone_sum_r >= $past(lone_sum_r)))
    else $error("dead-time total decreased");

  a_muon_opens: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && muon) |=> (veto_open_r && !lone_open_r && veto_start_r == $past(item_stamp)))
    else $error("muon event did not open veto window");

  a_accept_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && accept) |=> (!veto_open_r && !lone_open_r))
    else $error("accepted event left a window open");

  a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> ($stable(veto_open_r) && $stable(lone_open_r) && $stable(veto_cnt_r)))
    else $error("state changed without an event");

endmodule

// ===== hdl/vdt_out_reg.sv =====
// Result register: holds one result request until the downstream side takes it.
module vdt_out_reg (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          load,
  input  vdt_pkg::res_t res_in,
  output logic          ready,
  output logic          out_valid,
  input  logic          out_stall,
  output vdt_pkg::res_t res_out
);
  import vdt_pkg::*;

  logic valid_r;
  logic valid_nxt;
  res_t res_r;

  assign ready = !valid_r || !out_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_in;
    end
  end

  assign out_valid = valid_r;
  assign res_out   = res_r;

endmodule

// ===== hdl/muon_veto_deadtime_tracker_top.sv =====
// Top level of the muon veto and dead-time tracker.
// Each event request passes an input register, the window and total update, and
// a result register, so one event is taken per clock while out_stall is low; its
// result is presented on out_valid from the result register, which loads when the
// update stage takes the event from the input register. The update reads and
// writes the veto and lone-follower state for every event.
// A result waiting on out_stall stalls the update stage, and the input side
// stalls once its register is also full. Configuration writes (index 0: hit
// threshold, index 1: veto window in ns) take effect on the next clock and
// should only be issued while no event is in flight.
module muon_veto_deadtime_tracker_top #(
  parameter int STAMP_BITS = 43
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [vdt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [vdt_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [STAMP_BITS-1:0]         in_timestamp,
  input  logic [vdt_pkg::HIT_W-1:0]     in_cleaned_hits,
  input  logic [vdt_pkg::FLAG_W-1:0]    in_cleaning_flags,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_accept,
  output logic [vdt_pkg::CNT_W-1:0]     out_veto_total,
  output logic [vdt_pkg::SUM_W-1:0]     out_pileup_ns,
  output logic [vdt_pkg::SUM_W-1:0]     out_lone_follower_ns
);
  import vdt_pkg::*;

  logic                  item_valid;
  logic                  out_ready;
  logic                  adv;
  logic [STAMP_BITS-1:0] item_stamp;
  logic [HIT_W-1:0]      item_hits;
  logic [FLAG_W-1:0]     item_flags;
  res_t                  res;
  res_t                  res_q;

  assign adv = item_valid && out_ready;

  vdt_in_reg #(.STAMP_BITS(STAMP_BITS)) u_in_reg (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_timestamp     (in_timestamp),
    .in_cleaned_hits  (in_cleaned_hits),
    .in_cleaning_flags(in_cleaning_flags),
    .item_valid       (item_valid),
    .item_take        (adv),
    .item_stamp       (item_stamp),
    .item_hits        (item_hits),
    .item_flags       (item_flags)
  );

  vdt_state #(.STAMP_BITS(STAMP_BITS)) u_state (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .adv       (adv),
    .item_stamp(item_stamp),
    .item_hits (item_hits),
    .item_flags(item_flags),
    .res       (res)
  );

  vdt_out_reg u_out_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (adv),
    .res_in   (res),
    .ready    (out_ready),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .res_out  (res_q)
  );

  assign out_accept           = res_q.accept;
  assign out_veto_total       = res_q.veto_total;
  assign out_pileup_ns        = res_q.pileup_ns;
  assign out_lone_follower_ns = res_q.lone_follower_ns;

endmodule
